// File: rtl/rx_byte_fifo_with_bracket_framer_top_assert.svh
// Assertion helpers shared by the block's modules.
// Both expect clk_i and rst_ni in scope.
`ifndef RX_BYTE_FIFO_WITH_BRACKET_FRAMER_TOP_ASSERT_SVH
`define RX_BYTE_FIFO_WITH_BRACKET_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication.
`define RBF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbf assertion failed");

// Next-cycle implication.
`define RBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rbf assertion failed");

`endif

// File: rtl/rbf_pkg.sv
package rbf_pkg;

  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned PKT_DEPTH  = 128;
  localparam int unsigned PKT_AW     = $clog2(PKT_DEPTH);

  localparam logic [7:0] OPEN_MARK  = 8'h5B;
  localparam logic [7:0] CLOSE_MARK = 8'h5D;

  typedef enum logic [1:0] {
    FUNC_RX   = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_ACK  = 2'd3
  } func_e;

  typedef struct packed {
    logic exec;
    logic load;
  } dp_cmd_t;

endpackage

// File: rtl/rbf_if.sv
interface rbf_in_if;
  logic              valid;
  logic              ready;
  rbf_pkg::func_e    func;
  logic [7:0]        rx_byte;
  logic [6:0]        pkt_index;

  modport source (output valid, func, rx_byte, pkt_index, input ready);
  modport sink   (input valid, func, rx_byte, pkt_index, output ready);
endinterface

interface rbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] fifo_byte;
  logic [8:0] fifo_count;
  logic       byte_dropped;
  logic       packet_ready;
  logic [6:0] packet_length;
  logic [7:0] packet_byte;

  modport source (output valid, fifo_byte, fifo_count, byte_dropped, packet_ready,
                  packet_length, packet_byte, input ready);
  modport sink   (input valid, fifo_byte, fifo_count, byte_dropped, packet_ready,
                  packet_length, packet_byte, output ready);
endinterface

// File: rtl/rbf_ctrl.sv
module rbf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_ready_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output rbf_pkg::dp_cmd_t cmd_o
);
  import rbf_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.exec = in_valid_i && (state_q == ST_IDLE);
    cmd_o.load = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.exec) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the output register is free
        if (cmd_o.load) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`include "rx_byte_fifo_with_bracket_framer_top_assert.svh"
  `RBF_ASSERT_NEXT(a_exec_follows_accept, cmd_o.exec, state_q == ST_EXEC)
  `RBF_ASSERT_NEXT(a_load_returns_idle, cmd_o.load, state_q == ST_IDLE && out_valid_q)
  `RBF_ASSERT_NEXT(a_free_slot_loads, state_q == ST_EXEC && !out_valid_q, out_valid_q)

endmodule

// File: rtl/rbf_dp.sv
module rbf_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rbf_pkg::dp_cmd_t cmd_i,
  input  rbf_pkg::func_e   func_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [6:0]       pkt_index_i,
  output logic [7:0]       fifo_byte_o,
  output logic [8:0]       fifo_count_o,
  output logic             byte_dropped_o,
  output logic             packet_ready_o,
  output logic [6:0]       packet_length_o,
  output logic [7:0]       packet_byte_o
);
  import rbf_pkg::*;

  logic [7:0]         fifo_mem [FIFO_DEPTH];
  logic [7:0]         pkt_mem  [PKT_DEPTH];

  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               in_frame_q, in_frame_d;
  logic [PKT_AW-1:0]  pos_q, pos_d;
  logic               pending_q, pending_d;
  logic [PKT_AW-1:0]  plen_q, plen_d;

  logic               sel_fifo_q, sel_pkt_q, dropped_q;
  logic [7:0]         fifo_rd_q, pkt_rd_q;

  logic [7:0]         fifo_byte_q, packet_byte_q;
  logic [CNT_W-1:0]   fifo_count_q;
  logic               byte_dropped_q, packet_ready_q;
  logic [6:0]         packet_length_q;

  logic full, empty, is_rx, push, pop, rd_hit, pkt_wr;

  always_comb begin
    full   = (count_q == CNT_W'(FIFO_DEPTH));
    empty  = (count_q == '0);
    is_rx  = cmd_i.exec && (func_i == FUNC_RX);
    push   = is_rx && !full;
    pop    = cmd_i.exec && (func_i == FUNC_POP) && !empty;
    rd_hit = pending_q && (pkt_index_i < plen_q);
    pkt_wr = is_rx && in_frame_q && (rx_byte_i != CLOSE_MARK)
             && (pos_q != PKT_AW'(PKT_DEPTH - 1));
  end

  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    count_d    = count_q;
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    pending_d  = pending_q;
    plen_d     = plen_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
      count_d  = count_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
      count_d  = count_q - 1'b1;
    end
    if (is_rx) begin
      if (!in_frame_q) begin
        if (rx_byte_i == OPEN_MARK && !pending_q) begin
          in_frame_d = 1'b1;
          pos_d      = '0;
        end
      end else if (rx_byte_i == CLOSE_MARK) begin
        in_frame_d = 1'b0;
        pending_d  = 1'b1;
        plen_d     = pos_q;
      end else if (pkt_wr) begin
        pos_d = pos_q + 1'b1;
      end else begin
        // frame overran the packet store: drop it
        in_frame_d = 1'b0;
      end
    end
    if (cmd_i.exec && func_i == FUNC_ACK) begin
      pending_d = 1'b0;
      plen_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      pending_q  <= 1'b0;
      plen_q     <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      count_q    <= count_d;
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      pending_q  <= pending_d;
      plen_q     <= plen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem[wr_ptr_q] <= rx_byte_i;
    end
    if (pop) begin
      fifo_rd_q <= fifo_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_wr) begin
      pkt_mem[pos_q] <= rx_byte_i;
    end
    if (cmd_i.exec && func_i == FUNC_READ) begin
      pkt_rd_q <= pkt_mem[pkt_index_i];
    end
  end

  // capture what the result needs besides the read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      sel_fifo_q <= pop;
      sel_pkt_q  <= (func_i == FUNC_READ) && rd_hit;
      dropped_q  <= is_rx && full;
    end
  end

  // state holds while the word is built, so counts come straight from it
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fifo_byte_q     <= sel_fifo_q ? fifo_rd_q : 8'h00;
      packet_byte_q   <= sel_pkt_q ? pkt_rd_q : 8'h00;
      fifo_count_q    <= count_q;
      byte_dropped_q  <= dropped_q;
      packet_ready_q  <= pending_q;
      packet_length_q <= pending_q ? plen_q : '0;
    end
  end

  assign fifo_byte_o     = fifo_byte_q;
  assign fifo_count_o    = fifo_count_q;
  assign byte_dropped_o  = byte_dropped_q;
  assign packet_ready_o  = packet_ready_q;
  assign packet_length_o = packet_length_q;
  assign packet_byte_o   = packet_byte_q;

`include "rx_byte_fifo_with_bracket_framer_top_assert.svh"
  `RBF_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(FIFO_DEPTH))
  `RBF_ASSERT_NOW(a_ptr_gap, 1'b1, count_q[FIFO_AW-1:0] == FIFO_AW'(wr_ptr_q - rd_ptr_q))
  `RBF_ASSERT_NOW(a_frame_excl_pending, in_frame_q, !pending_q)

endmodule

// File: rtl/rx_byte_fifo_with_bracket_framer_top.sv
// Channel  Dir  Word fields
// in_i     in   func, rx_byte, pkt_index
// out_o    out  fifo_byte, fifo_count, byte_dropped, packet_ready,
//                packet_length, packet_byte
//
// An item is accepted in ST_IDLE, where the memory access and the pointer and
// framer update happen; in ST_EXEC the output register is then loaded from
// the registered read data. No new item is taken until ST_EXEC has loaded it.
// A stalled output register holds ST_EXEC until it drains; the next
// item can be accepted while a result still waits.
// Reset clears pointers, counts and framer state; no clearing pass is needed.
module rx_byte_fifo_with_bracket_framer_top (
  input logic    clk_i,
  input logic    rst_ni,
  rbf_in_if.sink in_i,
  rbf_out_if.source out_o
);
  import rbf_pkg::*;

  dp_cmd_t cmd;

  rbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  rbf_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (in_i.func),
    .rx_byte_i       (in_i.rx_byte),
    .pkt_index_i     (in_i.pkt_index),
    .fifo_byte_o     (out_o.fifo_byte),
    .fifo_count_o    (out_o.fifo_count),
    .byte_dropped_o  (out_o.byte_dropped),
    .packet_ready_o  (out_o.packet_ready),
    .packet_length_o (out_o.packet_length),
    .packet_byte_o   (out_o.packet_byte)
  );

endmodule
